// File: hw/rtl/ecp_rle_pkg.sv
// ----------------------------------------------------------------------------
// ecp_rle_pkg
// Shared types and constants of the ECP reverse-channel RLE receiver.
// ----------------------------------------------------------------------------
package ecp_rle_pkg;

    localparam int unsigned LEN_BITS = 16;
    localparam logic [7:0]  CHANNEL_CMD_BIT = 8'h80;

    typedef enum logic {
        OP_START    = 1'b0,
        OP_TRANSFER = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_DATA     = 3'd0,
        ST_RUN_CNT  = 3'd1,
        ST_CHAN_CMD = 3'd2,
        ST_RUN_LONG = 3'd3,
        ST_ACK_TOUT = 3'd4,
        ST_IGNORED  = 3'd5,
        ST_STARTED  = 3'd6
    } t_status;

    typedef struct packed {
        t_op        op;
        logic [7:0] data_byte;
        logic       busy_line;
        logic       late_ack;
    } t_ecp_in;

    typedef struct packed {
        logic [7:0]          out_byte;
        logic [7:0]          repeat_res;
        t_status             status;
        logic [LEN_BITS-1:0] delivered;
        logic                done_res;
    } t_ecp_out;

endpackage

// File: hw/rtl/ecp_rle_decide.sv
// ----------------------------------------------------------------------------
// ecp_rle_decide
// Request state, length register and the per-beat decode decision.
// ----------------------------------------------------------------------------
module ecp_rle_decide
    import ecp_rle_pkg::*;
#(
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [LEN_BITS-1:0] i_cfg_data,
    input  logic                i_accept,
    input  t_ecp_in             i_item,
    output t_ecp_out            o_result
);

    localparam int unsigned CW = (COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS;

    logic [LEN_BITS-1:0]   r_req_len;
    logic                  r_active,      n_active;
    logic                  r_run_pending, n_run_pending;
    logic [7:0]            r_run_length,  n_run_length;
    logic [COUNT_BITS-1:0] r_byte_count,  n_byte_count;

    logic [CW-1:0]         w_len;
    logic [CW-1:0]         w_cnt;
    logic [CW-1:0]         w_remaining;
    logic [7:0]            w_copies;
    logic [COUNT_BITS:0]   w_sum;

    assign w_len       = CW'(r_req_len);
    assign w_cnt       = CW'(r_byte_count);
    assign w_remaining = (w_len > w_cnt) ? (w_len - w_cnt) : '0;
    // stored run length has bit 7 clear, so copies fit in eight bits
    assign w_copies    = r_run_pending ? (r_run_length + 8'd1) : 8'd1;
    assign w_sum       = {1'b0, r_byte_count} + (COUNT_BITS+1)'(w_copies);

    always_comb begin
        n_active      = r_active;
        n_run_pending = r_run_pending;
        n_run_length  = r_run_length;
        n_byte_count  = r_byte_count;
        o_result.out_byte   = '0;
        o_result.repeat_res = '0;
        o_result.status     = ST_IGNORED;

        if (i_item.op == OP_START) begin
            n_active          = (r_req_len != '0);
            n_run_pending     = 1'b0;
            n_run_length      = '0;
            n_byte_count      = '0;
            o_result.status   = ST_STARTED;
        end else if (r_active) begin
            if (w_remaining == '0) begin
                o_result.status = ST_IGNORED;
                n_active        = 1'b0;
            end else if (!r_run_pending && i_item.busy_line) begin
                if ((i_item.data_byte & CHANNEL_CMD_BIT) != '0) begin
                    o_result.status = ST_CHAN_CMD;
                    n_active        = 1'b0;
                end else if (CW'({1'b0, i_item.data_byte} + 9'd1) > w_remaining) begin
                    o_result.status = ST_RUN_LONG;
                    n_active        = 1'b0;
                end else if (i_item.late_ack) begin
                    o_result.status = ST_ACK_TOUT;
                    n_active        = 1'b0;
                end else begin
                    n_run_pending   = 1'b1;
                    n_run_length    = i_item.data_byte;
                    o_result.status = ST_RUN_CNT;
                end
            end else if (i_item.late_ack) begin
                o_result.status = ST_ACK_TOUT;
                n_active        = 1'b0;
            end else if (CW'(w_copies) > w_remaining) begin
                o_result.status = ST_RUN_LONG;
                n_active        = 1'b0;
            end else begin
                o_result.out_byte   = i_item.data_byte;
                o_result.repeat_res = w_copies;
                o_result.status     = ST_DATA;
                n_run_pending       = 1'b0;
                n_run_length        = '0;
                n_byte_count        = w_sum[COUNT_BITS] ? '1 : w_sum[COUNT_BITS-1:0];
                if (CW'(n_byte_count) >= w_len) begin
                    n_active = 1'b0;
                end
            end
        end

        // leaving a request drops any half-taken run
        if (!n_active) begin
            n_run_pending = 1'b0;
            n_run_length  = '0;
        end
        o_result.delivered = (CW'(n_byte_count) > CW'({LEN_BITS{1'b1}})) ? '1
                             : LEN_BITS'(CW'(n_byte_count));
        o_result.done_res  = !n_active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_len     <= LEN_BITS'(1);
            r_active      <= 1'b0;
            r_run_pending <= 1'b0;
            r_run_length  <= '0;
            r_byte_count  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_req_len <= i_cfg_data;
            end
            if (i_accept) begin
                r_active      <= n_active;
                r_run_pending <= n_run_pending;
                r_run_length  <= n_run_length;
                r_byte_count  <= n_byte_count;
            end
        end
    end

endmodule

// File: hw/rtl/ecp_rle_skid.sv
// ----------------------------------------------------------------------------
// ecp_rle_skid
// Result register with one skid entry, so a beat is taken while a result waits.
// ----------------------------------------------------------------------------
module ecp_rle_skid
    import ecp_rle_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_ecp_out i_data,
    output logic     o_full,
    output logic     o_valid,
    input  logic     i_stall,
    output t_ecp_out o_data
);

    logic     r_out_valid;
    logic     r_skid_valid;
    t_ecp_out r_out;
    t_ecp_out r_skid;
    logic     w_pop;

    assign w_pop   = r_out_valid && !i_stall;
    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_out <= r_skid_valid ? r_skid : i_data;
        end else if (i_push && !r_out_valid) begin
            r_out <= i_data;
        end
        if (i_push && r_out_valid && !w_pop) begin
            r_skid <= i_data;
        end
    end

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without a result in front");

    a_push_into_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && r_out_valid && !w_pop) |=> r_skid_valid)
        else $error("beat behind a stalled result was lost");

    a_drain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !r_skid_valid && !i_push) |=> !r_out_valid)
        else $error("result repeated after it was taken");

endmodule

// File: hw/rtl/ecp_reverse_rle_receiver_unit.sv
// ----------------------------------------------------------------------------
// ecp_reverse_rle_receiver_unit
// ECP reverse-channel receiver with run-length decoding, one result per beat.
// ----------------------------------------------------------------------------
// The decode is combinational; its result is registered in the result buffer.
// Throughput: one beat per cycle while the result buffer is not full; the decode is a single pass on the state.
// A two-entry result buffer keeps input flowing while one result waits.
// Reset (synchronous, active low): no request running, counts cleared,
// request_length back to 1, result buffer empty.
module ecp_reverse_rle_receiver_unit
    import ecp_rle_pkg::*;
#(
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_ecp_in             i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_ecp_out            o_out_data,
    input  logic                i_cfg_we,
    input  logic [LEN_BITS-1:0] i_cfg_data
);

    logic     w_accept;
    logic     w_full;
    t_ecp_out w_result;

    assign o_in_stall = w_full;
    assign w_accept   = i_in_valid && !w_full;

    ecp_rle_decide #(
        .COUNT_BITS (COUNT_BITS)
    ) u_decide (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_accept   (w_accept),
        .i_item     (i_in_data),
        .o_result   (w_result)
    );

    ecp_rle_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_result),
        .o_full  (w_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ECP reverse-channel RLE receiver: a directed
// table of beats (idle transfers, zero-length and full-length requests,
// channel commands, run counts, over-long runs, late acks) followed by
// shaped random requests over several length settings and idling phases.
// Every result is checked in order, against the table's expected value or a local decode model.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ecp_rle_pkg::*;

    typedef enum {ROW_BEAT, ROW_LEN} t_row_kind;
    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle;

    typedef struct {
        t_row_kind   kind;
        logic [15:0] len_val;
        t_ecp_in     beat;
        bit          chk;
        t_ecp_out    exp;
    } t_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    t_ecp_in             i_in_data;
    logic                o_out_valid;
    logic                i_out_stall;
    t_ecp_out            o_out_data;
    logic                i_cfg_we;
    logic [LEN_BITS-1:0] i_cfg_data;

    ecp_reverse_rle_receiver_unit #(
        .COUNT_BITS (16)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    // decode model state
    int unsigned req_len_q = 1;
    bit          req_open  = 0;
    bit          cnt_armed = 0;
    int unsigned cnt_value = 0;
    int unsigned bytes_out = 0;

    t_ecp_out    pending_results[$];
    t_ecp_out    predicted;
    int unsigned err_cnt = 0;
    t_idle       idle_mode = IDLE_NONE;
    bit          row_chk = 0;
    t_ecp_out    row_exp;
    t_row        dir_tab[$];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("ecp_reverse_rle_receiver_unit regression: fail");
        $finish;
    end

    function automatic void drop_request();
        req_open  = 0;
        cnt_armed = 0;
        cnt_value = 0;
    endfunction

    function automatic t_ecp_out decode_beat(t_ecp_in b);
        t_ecp_out    r;
        int unsigned room;
        int unsigned copies;
        r = '0;
        r.status = ST_IGNORED;
        if (b.op == OP_START) begin
            req_open  = 1;
            cnt_armed = 0;
            cnt_value = 0;
            bytes_out = 0;
            r.status  = ST_STARTED;
            if (req_len_q == 0) drop_request();
        end else if (req_open) begin
            room = (req_len_q > bytes_out) ? req_len_q - bytes_out : 0;
            if (room == 0) begin
                drop_request();
            end else if (!cnt_armed && b.busy_line) begin
                if (|(b.data_byte & CHANNEL_CMD_BIT)) begin
                    r.status = ST_CHAN_CMD;
                    drop_request();
                end else if (int'(b.data_byte) + 1 > room) begin
                    r.status = ST_RUN_LONG;
                    drop_request();
                end else if (b.late_ack) begin
                    r.status = ST_ACK_TOUT;
                    drop_request();
                end else begin
                    cnt_armed = 1;
                    cnt_value = 32'(b.data_byte);
                    r.status  = ST_RUN_CNT;
                end
            end else if (b.late_ack) begin
                r.status = ST_ACK_TOUT;
                drop_request();
            end else begin
                copies = cnt_armed ? cnt_value + 1 : 1;
                if (copies > room) begin
                    r.status = ST_RUN_LONG;
                    drop_request();
                end else begin
                    r.out_byte   = b.data_byte;
                    r.repeat_res = 8'(copies);
                    r.status     = ST_DATA;
                    cnt_armed    = 0;
                    cnt_value    = 0;
                    // count saturates at its width
                    bytes_out = (bytes_out + copies > 65535) ? 65535 : bytes_out + copies;
                    if (bytes_out >= req_len_q) drop_request();
                end
            end
        end
        r.delivered = 16'(bytes_out);
        r.done_res  = !req_open;
        return r;
    endfunction

    task automatic check_result(t_ecp_out exp, t_ecp_out act);
        if (act.out_byte !== exp.out_byte || act.repeat_res !== exp.repeat_res ||
            act.status !== exp.status || act.delivered !== exp.delivered ||
            act.done_res !== exp.done_res) begin
            err_cnt++;
            $display("%0t: result mismatch exp byte=%h rep=%0d st=%0d del=%0d done=%b",
                     $time, exp.out_byte, exp.repeat_res, exp.status, exp.delivered,
                     exp.done_res);
            $display("%0t:                 got byte=%h rep=%0d st=%0d del=%0d done=%b",
                     $time, act.out_byte, act.repeat_res, act.status, act.delivered,
                     act.done_res);
        end
    endtask

    // model update and scoreboard, both on the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) req_len_q = 32'(i_cfg_data);
            if (i_in_valid && !o_in_stall) begin
                predicted = decode_beat(i_in_data);
                pending_results.push_back(row_chk ? row_exp : predicted);
            end
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected result exp none got byte=%h rep=%0d st=%0d",
                             $time, o_out_data.out_byte, o_out_data.repeat_res,
                             o_out_data.status);
                end else begin
                    check_result(pending_results.pop_front(), o_out_data);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= (idle_mode == IDLE_RECV && $urandom_range(0, 99) < 81) ||
                       (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 13);
    end

    task automatic send_beat(t_ecp_in b, bit chk, t_ecp_out exp);
        @(negedge i_clk);
        while ((idle_mode == IDLE_SEND && $urandom_range(0, 99) < 81) ||
               (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 13)) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        row_chk = chk;
        row_exp = exp;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // only while nothing is in flight
    task automatic write_length(logic [15:0] v);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic add_checked(t_op op, logic [7:0] b, logic busy, logic late,
                               logic [7:0] ob, logic [7:0] rep, t_status st,
                               logic [15:0] del, logic done, bit chk = 1);
        t_row r;
        r.kind           = ROW_BEAT;
        r.len_val        = '0;
        r.beat.op        = op;
        r.beat.data_byte = b;
        r.beat.busy_line = busy;
        r.beat.late_ack  = late;
        r.chk            = chk;
        r.exp.out_byte   = ob;
        r.exp.repeat_res = rep;
        r.exp.status     = st;
        r.exp.delivered  = del;
        r.exp.done_res   = done;
        dir_tab.push_back(r);
    endtask

    task automatic add_beat(t_op op, logic [7:0] b, logic busy, logic late);
        add_checked(op, b, busy, late, 8'h00, 8'd0, ST_DATA, 16'd0, 1'b0, 0);
    endtask

    task automatic add_len(logic [15:0] v);
        t_row r;
        r.kind    = ROW_LEN;
        r.len_val = v;
        r.beat    = '0;
        r.chk     = 1'b0;
        r.exp     = '0;
        dir_tab.push_back(r);
    endtask

    // shaped random beat: mostly well-formed requests, some noise
    function automatic t_ecp_in gen_beat();
        t_ecp_in     b;
        int unsigned sel;
        b.op        = OP_TRANSFER;
        b.data_byte = 8'($urandom_range(0, 255));
        b.busy_line = 1'($urandom_range(0, 1));
        b.late_ack  = ($urandom_range(0, 99) < 3);
        sel = $urandom_range(0, 99);
        if (!req_open) begin
            if (sel < 85) b.op = OP_START;
        end else if (sel < 4) begin
            b.op = OP_START;
        end else if (!cnt_armed) begin
            if (sel < 24) begin
                b.busy_line = 1'b1;
                sel = $urandom_range(0, 99);
                if (sel < 70)      b.data_byte = 8'($urandom_range(0, 7));
                else if (sel < 92) b.data_byte = 8'($urandom_range(0, 127));
                else               b.data_byte = 8'($urandom_range(128, 255));
            end else begin
                b.busy_line = 1'b0;
            end
        end
        return b;
    endfunction

    initial begin
        t_ecp_in     nb;
        bit          counts;
        bit          mid_written;
        int unsigned counted;
        logic [15:0] len_v;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_stall = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        add_checked(OP_TRANSFER, 8'h00, 0, 0, 8'h00, 8'd0,   ST_IGNORED,  16'd0,   1);
        add_checked(OP_START,    8'h00, 0, 0, 8'h00, 8'd0,   ST_STARTED,  16'd0,   0);
        add_checked(OP_TRANSFER, 8'hFF, 0, 0, 8'hFF, 8'd1,   ST_DATA,     16'd1,   1);
        add_len(16'd0);
        add_checked(OP_START,    8'hFF, 1, 1, 8'h00, 8'd0,   ST_STARTED,  16'd0,   1);
        add_len(16'hFFFF);
        add_checked(OP_START,    8'h00, 0, 0, 8'h00, 8'd0,   ST_STARTED,  16'd0,   0);
        add_checked(OP_TRANSFER, 8'h7F, 1, 0, 8'h00, 8'd0,   ST_RUN_CNT,  16'd0,   0);
        // busy high after a count is still data
        add_checked(OP_TRANSFER, 8'hA5, 1, 0, 8'hA5, 8'd128, ST_DATA,     16'd128, 0);
        add_checked(OP_TRANSFER, 8'h00, 1, 1, 8'h00, 8'd0,   ST_ACK_TOUT, 16'd128, 1);
        add_beat(OP_START, 8'h00, 0, 0);
        add_checked(OP_TRANSFER, 8'h80, 1, 1, 8'h00, 8'd0,   ST_CHAN_CMD, 16'd0,   1);
        add_len(16'd5);
        add_beat(OP_START, 8'h00, 0, 0);
        add_checked(OP_TRANSFER, 8'h05, 1, 0, 8'h00, 8'd0,   ST_RUN_LONG, 16'd0,   1);
        add_beat(OP_START, 8'h00, 0, 0);
        add_beat(OP_TRANSFER, 8'h04, 1, 0);
        add_checked(OP_TRANSFER, 8'h3C, 0, 0, 8'h3C, 8'd5,   ST_DATA,     16'd5,   1);
        // length lowered under a pending run: refused on the data byte
        add_len(16'd10);
        add_beat(OP_START, 8'h00, 0, 0);
        add_beat(OP_TRANSFER, 8'h03, 1, 0);
        add_len(16'd2);
        add_checked(OP_TRANSFER, 8'h55, 0, 0, 8'h00, 8'd0,   ST_RUN_LONG, 16'd0,   1);
        add_len(16'd10);
        add_beat(OP_START, 8'h00, 0, 0);
        add_beat(OP_TRANSFER, 8'h02, 1, 0);
        add_checked(OP_TRANSFER, 8'h77, 0, 1, 8'h00, 8'd0,   ST_ACK_TOUT, 16'd0,   1);
        add_beat(OP_START, 8'h00, 0, 0);
        add_beat(OP_TRANSFER, 8'h01, 0, 0);
        add_beat(OP_TRANSFER, 8'h02, 0, 0);
        // length lowered below the count already delivered
        add_len(16'd1);
        add_checked(OP_TRANSFER, 8'hAA, 0, 0, 8'h00, 8'd0,   ST_IGNORED,  16'd2,   1);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_LEN) write_length(dir_tab[i].len_val);
            else send_beat(dir_tab[i].beat, dir_tab[i].chk, dir_tab[i].exp);
        end

        // random phases over lengths and idling patterns
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0:       len_v = 16'hFFFF;
                1:       len_v = 16'd1;
                2, 6:    len_v = 16'($urandom_range(2, 40));
                3:       len_v = 16'($urandom_range(1, 300));
                4:       len_v = 16'd0;
                default: len_v = 16'($urandom_range(0, 65535));
            endcase
            write_length(len_v);
            idle_mode   = t_idle'(ph % 4);
            counted     = 0;
            mid_written = 0;
            while (counted < 170) begin
                if (counted == 85 && !mid_written) begin
                    mid_written = 1;
                    write_length(16'($urandom_range(0, 60)));
                end
                nb = gen_beat();
                counts = (nb.op == OP_START) || req_open;
                send_beat(nb, 0, '0);
                if (counts) counted++;
            end
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("ecp_reverse_rle_receiver_unit regression: pass");
        end else begin
            $display("ecp_reverse_rle_receiver_unit regression: fail");
        end
        $finish;
    end

endmodule
